/* src/hrm_pkg.sv */
`default_nettype none

package hrm_pkg;

    localparam int DATA_W    = 32;
    localparam int REQ_W     = 2;
    localparam int AGE_W     = 10;
    localparam int CAP_W     = 9;
    localparam int DEPTH_DEF = 256;
    localparam int CAP_RESET = 256;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 2'd0,
        REQ_READ   = 2'd1,
        REQ_MEAN   = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_WALK,
        ST_DRAIN,
        ST_DIV_GO,
        ST_DIV_WAIT
    } state_t;

endpackage

`default_nettype wire

/* src/hrm_ram.sv */
`default_nettype none

module hrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/hrm_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle, truncates toward zero.
module hrm_div
    import hrm_pkg::*;
#(
    parameter int SW = 41,
    parameter int CW = 9
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [SW-1:0]     dividend,
    input  wire logic        [CW-1:0]     divisor,
    output logic                          done,
    output logic signed [DATA_W-1:0]      quotient
);

    localparam int NW = $clog2(SW + 1);

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    logic              neg_reg,  neg_next;
    logic [NW-1:0]     cnt_reg,  cnt_next;
    logic [CW-1:0]     rem_reg,  rem_next;
    logic [SW-1:0]     q_reg,    q_next;
    logic [CW-1:0]     dvs_reg,  dvs_next;

    logic [CW:0]       rem_sh;
    logic [CW+1:0]     diff;
    logic [SW-1:0]     q_signed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            neg_reg  <= neg_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign rem_sh = {rem_reg, q_reg[SW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            run_next = 1'b1;
            neg_next = dividend[SW-1];
            q_next   = dividend[SW-1] ? (~dividend + 1'b1) : dividend;
            rem_next = '0;
            cnt_next = NW'(SW);
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            // no borrow: divisor fits, take the subtraction
            if (!diff[CW+1])
            begin
                rem_next = diff[CW-1:0];
                q_next   = {q_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[CW-1:0];
                q_next   = {q_reg[SW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign q_signed = neg_reg ? (~q_reg + 1'b1) : q_reg;
    assign quotient = q_signed[DATA_W-1:0];
    assign done     = done_reg;

endmodule

`default_nettype wire

/* src/history_ring_with_window_mean.sv */
`default_nettype none

// Append: taken while idle, no result; the next item can start the cycle after.
// Read by age: RAM read, then ST_RD_WAIT, then the result register and strobe; empty store: 0.
// Mean: the n entries of the window are read (one RAM read per cycle) and summed, then
//   divided in SW = 32 + clog2(DEPTH+1) serial divide steps (41 at DEPTH 256); empty: 0.
// The receiver cannot stall; busy stays high until the result strobe is issued.
// Reset: history empty, capacity min(256, DEPTH); RAM contents are left as they are.
module history_ring_with_window_mean
    import hrm_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [REQ_W-1:0]         req_type,
    input  wire logic signed [DATA_W-1:0] sample,
    input  wire logic [AGE_W-1:0]         start_age,
    input  wire logic [AGE_W-1:0]         end_age,
    output logic signed [DATA_W-1:0]      result,
    output logic                          result_valid,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CAP_W-1:0]         cfg_data
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int LW      = ((CW > AGE_W) ? CW : AGE_W) + 1;
    localparam int IW      = LW + 1;
    localparam int SW      = DATA_W + CW;
    localparam int CAP_RST = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

    state_t                  state_reg,  state_next;
    logic [AW-1:0]           wp_reg,     wp_next;
    logic [CW-1:0]           fill_reg,   fill_next;
    logic [CW-1:0]           cap_reg,    cap_next;
    logic [CW-1:0]           age_reg,    age_next;
    logic [CW-1:0]           end_reg,    end_next;
    logic [CW-1:0]           cnt_reg,    cnt_next;
    logic signed [SW-1:0]    sum_reg,    sum_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [DATA_W-1:0]       result_reg, result_next;
    logic                    strobe_reg, strobe_next;

    logic                    accept;
    logic [LW-1:0]           fill_ext, wp_ext, cap_ext, sa_ext, ea_ext, cfg_ext;
    logic [CW-1:0]           fill_m1, sa_cl, ea_cl, age_sel;
    logic [IW-1:0]           idx_t, idx;
    logic [AW-1:0]           raddr, waddr;
    logic                    wr_fill;
    logic [LW-1:0]           f1, wp1, cap_new;
    logic [AW-1:0]           app_wp;
    logic [CW-1:0]           app_fill;
    logic                    ram_we;
    logic [DATA_W-1:0]       rdata;
    logic                    div_start, div_done;
    logic signed [DATA_W-1:0] div_q;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = start && !busy;

    assign fill_ext = LW'(fill_reg);
    assign wp_ext   = LW'(wp_reg);
    assign cap_ext  = LW'(cap_reg);
    assign sa_ext   = LW'(start_age);
    assign ea_ext   = LW'(end_age);
    assign cfg_ext  = LW'(cfg_data);
    assign fill_m1  = fill_reg - 1'b1;

    // ages clamp to the oldest stored entry
    assign sa_cl = (sa_ext >= fill_ext) ? fill_m1 : sa_ext[CW-1:0];
    assign ea_cl = (ea_ext >= fill_ext) ? fill_m1 : ea_ext[CW-1:0];

    // shared age-to-slot unit: slot = wp - 1 - age, wrapped by fill count
    assign age_sel = (state_reg == ST_IDLE) ? sa_cl : age_reg;
    assign idx_t   = IW'(wp_reg) - IW'(1) - IW'(age_sel);
    assign idx     = idx_t[IW-1] ? (idx_t + IW'(fill_reg)) : idx_t;
    assign raddr   = idx[AW-1:0];

    // append: grow while filling, then overwrite at the write pointer
    assign wr_fill  = (fill_ext <= wp_ext);
    assign waddr    = wr_fill ? fill_reg[AW-1:0] : wp_reg;
    assign f1       = fill_ext + 1'b1;
    assign wp1      = wr_fill ? f1 : (wp_ext + 1'b1);
    assign app_wp   = (wp1 >= cap_ext) ? '0 : wp1[AW-1:0];
    assign app_fill = wr_fill ? ((f1 > cap_ext) ? cap_reg : f1[CW-1:0]) : fill_reg;
    assign ram_we   = accept && (req_type == REQ_APPEND);

    assign cap_new = (cfg_ext == '0)          ? LW'(1)     :
                     (cfg_ext > LW'(DEPTH))   ? LW'(DEPTH) : cfg_ext;

    assign div_start = (state_reg == ST_DIV_GO);

    hrm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    hrm_div #(
        .SW (SW),
        .CW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wp_reg     <= '0;
            fill_reg   <= '0;
            cap_reg    <= CW'(CAP_RST);
            age_reg    <= '0;
            end_reg    <= '0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            rd_vld_reg <= 1'b0;
            result_reg <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            cap_reg    <= cap_next;
            age_reg    <= age_next;
            end_reg    <= end_next;
            cnt_reg    <= cnt_next;
            sum_reg    <= sum_next;
            rd_vld_reg <= rd_vld_next;
            result_reg <= result_next;
            strobe_reg <= strobe_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        cap_next    = cap_reg;
        age_next    = age_reg;
        end_next    = end_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        rd_vld_next = 1'b0;
        result_next = result_reg;
        strobe_next = 1'b0;

        if ((state_reg == ST_WALK || state_reg == ST_DRAIN) && rd_vld_reg)
        begin
            sum_next = sum_reg + {{CW{rdata[DATA_W-1]}}, rdata};
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_APPEND:
                        begin
                            wp_next   = app_wp;
                            fill_next = app_fill;
                        end
                        REQ_READ:
                        begin
                            if (fill_reg == '0)
                            begin
                                result_next = '0;
                                strobe_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_RD_WAIT;
                            end
                        end
                        REQ_MEAN:
                        begin
                            if (fill_reg == '0 || sa_cl > ea_cl)
                            begin
                                result_next = '0;
                                strobe_next = 1'b1;
                            end
                            else
                            begin
                                age_next   = sa_cl;
                                end_next   = ea_cl;
                                cnt_next   = ea_cl - sa_cl + 1'b1;
                                sum_next   = '0;
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                result_next = rdata;
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_WALK:
            begin
                rd_vld_next = 1'b1;
                age_next    = age_reg + 1'b1;
                if (age_reg == end_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    result_next = div_q;
                    strobe_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // capacity write restarts the history
        if (cfg_valid && cfg_ready)
        begin
            cap_next  = cap_new[CW-1:0];
            wp_next   = '0;
            fill_next = '0;
        end
    end

    assign result       = result_reg;
    assign result_valid = strobe_reg;

`ifndef SYNTHESIS
    a_fill_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cap_reg)
        else $error("fill count above capacity");

    a_wp_lt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        wp_ext < cap_ext)
        else $error("write pointer out of range");

    a_filling_wp: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != cap_reg) |-> (wp_ext == fill_ext))
        else $error("write pointer off fill count while filling");

    a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_WAIT && div_done) |=> (result_valid && !busy))
        else $error("mean result not issued");
`endif

endmodule

`default_nettype wire
